// ===== sv/edc2d_pkg.sv =====
// ----------------------------------------------------------------------------
// Elastic disc collision package
// Shared payload types, widths and defaults of the two-dimensional elastic
// disc collision unit.
// ----------------------------------------------------------------------------
package edc2d_pkg;

    localparam int VEL_W             = 24;
    localparam int MASS_W            = 8;
    localparam int FRAC_BITS_DEFAULT = 8;

    // Distance and product widths, fixed by the 24-bit field format.
    localparam int DIFF_W = VEL_W + 1;            // centre and velocity differences
    localparam int SQ_W   = 2 * VEL_W + 1;        // one squared component
    localparam int D2_W   = SQ_W + 1;             // squared distance
    localparam int DOT_W  = 2 * DIFF_W + 1;       // relative velocity dot distance
    localparam int MSUM_W = MASS_W + 1;
    localparam int SC_W   = DOT_W + MSUM_W;       // 2 * mass * |dot|
    localparam int HALF_W = SC_W / 2;
    localparam int PP_W   = HALF_W + DIFF_W;      // one partial product
    localparam int NUM_W  = SC_W + DIFF_W;        // division numerator
    localparam int DEN_W  = D2_W + MSUM_W + 1;    // divisor and remainder
    // The correction never exceeds twice the relative speed, below 2^26.
    localparam int QUO_W  = 28;
    localparam int LANES  = 4;

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VEL_W-1:0] first_pos_x;
        logic signed [VEL_W-1:0] first_pos_y;
        logic signed [VEL_W-1:0] first_vel_x;
        logic signed [VEL_W-1:0] first_vel_y;
        logic        [MASS_W-1:0] first_mass;
        logic signed [VEL_W-1:0] second_pos_x;
        logic signed [VEL_W-1:0] second_pos_y;
        logic signed [VEL_W-1:0] second_vel_x;
        logic signed [VEL_W-1:0] second_vel_y;
        logic        [MASS_W-1:0] second_mass;
    } disc_pair_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] new_first_vel_x;
        logic signed [VEL_W-1:0] new_first_vel_y;
        logic signed [VEL_W-1:0] new_second_vel_x;
        logic signed [VEL_W-1:0] new_second_vel_y;
        logic                    hit;
    } disc_result_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] nlo;
    } div_lane_t;

    // Data that travels alongside the divider lanes.
    typedef struct packed {
        logic signed [LANES-1:0][VEL_W-1:0] vel;
        logic                               hit;
        logic                               neg_x;
        logic                               neg_y;
        logic [DEN_W-1:0]                   den;
    } div_ctx_t;

endpackage

// ===== sv/elastic_disc_collision_2d_unit.sv =====
// ----------------------------------------------------------------------------
// Elastic disc collision unit
// Resolves the elastic collision of two overlapping discs in fixed point.
// ----------------------------------------------------------------------------
// The unit takes one disc pair per clock while in_ready is high and returns one
// result per pair, in order. Most stages belong to the restoring divider, one
// quotient bit per stage across four parallel lanes; the other eight stages
// form the distance, dot product, the overlap test, the split numerator
// products, rounding and saturation.
// Each stage only holds while the stage after it is full and stalled, so
// empty slots fill up during an output stall.
module elastic_disc_collision_2d_unit #(
    parameter int FRAC_BITS = edc2d_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  edc2d_pkg::disc_pair_t    in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output edc2d_pkg::disc_result_t  out_data
);

    localparam int VW   = edc2d_pkg::VEL_W;
    localparam int DFW  = edc2d_pkg::DIFF_W;
    localparam int QW   = edc2d_pkg::QUO_W;
    localparam int DW   = edc2d_pkg::DEN_W;
    localparam int NW   = edc2d_pkg::NUM_W;
    localparam int HW   = edc2d_pkg::HALF_W;
    localparam int PW   = edc2d_pkg::PP_W;
    localparam int SCW  = edc2d_pkg::SC_W;
    localparam int NL   = edc2d_pkg::LANES;
    localparam int RW   = FRAC_BITS + 9;          // 3 * mass sum, in position units
    localparam int CW   = 2 * RW;
    localparam int CMPW = ((CW > edc2d_pkg::D2_W) ? CW : edc2d_pkg::D2_W) + 1;
    localparam int SUMW = ((QW + 2 > VW) ? QW + 2 : VW) + 1;

    // Stage indices.
    localparam int S_DIFF = 0;
    localparam int S_PROD = 1;
    localparam int S_SUM  = 2;
    localparam int S_SCAL = 3;
    localparam int S_PART = 4;
    localparam int S_NUM  = 5;
    localparam int S_RND  = S_NUM + QW + 1;
    localparam int S_OUT  = S_RND + 1;
    localparam int NS     = S_OUT + 1;

    logic [NS-1:0] v_reg, v_next, adv;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
                v_next[i] = v_reg[i-1];
            else
                v_next[i] = v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[S_OUT];

    // ---------------- Stage: differences ----------------
    logic signed [DFW-1:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic [edc2d_pkg::MASS_W-1:0] m1_reg, m2_reg;
    logic signed [NL-1:0][VW-1:0] vel1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_DIFF])
        begin
            dx_reg   <= {in_data.second_pos_x[VW-1], in_data.second_pos_x}
                      - {in_data.first_pos_x[VW-1], in_data.first_pos_x};
            dy_reg   <= {in_data.second_pos_y[VW-1], in_data.second_pos_y}
                      - {in_data.first_pos_y[VW-1], in_data.first_pos_y};
            dvx_reg  <= {in_data.second_vel_x[VW-1], in_data.second_vel_x}
                      - {in_data.first_vel_x[VW-1], in_data.first_vel_x};
            dvy_reg  <= {in_data.second_vel_y[VW-1], in_data.second_vel_y}
                      - {in_data.first_vel_y[VW-1], in_data.first_vel_y};
            m1_reg   <= in_data.first_mass;
            m2_reg   <= in_data.second_mass;
            vel1_reg <= {in_data.first_vel_x, in_data.first_vel_y,
                         in_data.second_vel_x, in_data.second_vel_y};
        end
    end

    // ---------------- Stage: products ----------------
    logic [DFW-1:0]                 adx_next, ady_next;
    logic [DFW-1:0]                 adx2_reg, ady2_reg;
    logic                           dxn2_reg, dyn2_reg;
    logic signed [2*DFW-1:0]        px_reg, py_reg;
    logic [edc2d_pkg::SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [edc2d_pkg::MSUM_W-1:0]   msum_next, msum2_reg;
    logic [RW-1:0]                  rsum_reg;
    logic [edc2d_pkg::MASS_W-1:0]   m1b_reg, m2b_reg;
    logic signed [NL-1:0][VW-1:0]   vel2_reg;

    assign adx_next  = dx_reg[DFW-1] ? DFW'(-dx_reg) : DFW'(dx_reg);
    assign ady_next  = dy_reg[DFW-1] ? DFW'(-dy_reg) : DFW'(dy_reg);
    assign msum_next = edc2d_pkg::MSUM_W'(m1_reg) + edc2d_pkg::MSUM_W'(m2_reg);

    always_ff @(posedge clk)
    begin
        if (adv[S_PROD])
        begin
            adx2_reg  <= adx_next;
            ady2_reg  <= ady_next;
            dxn2_reg  <= dx_reg[DFW-1];
            dyn2_reg  <= dy_reg[DFW-1];
            px_reg    <= dvx_reg * dx_reg;
            py_reg    <= dvy_reg * dy_reg;
            sqx_reg   <= edc2d_pkg::SQ_W'(adx_next * adx_next);
            sqy_reg   <= edc2d_pkg::SQ_W'(ady_next * ady_next);
            msum2_reg <= msum_next;
            rsum_reg  <= RW'(11'(msum_next) * 11'd3) << (FRAC_BITS - 2);
            m1b_reg   <= m1_reg;
            m2b_reg   <= m2_reg;
            vel2_reg  <= vel1_reg;
        end
    end

    // ---------------- Stage: sums ----------------
    logic signed [edc2d_pkg::DOT_W-1:0] s_reg;
    logic [edc2d_pkg::D2_W-1:0]         d2_reg;
    logic [CW-1:0]                      rsq_reg;
    logic [DFW-1:0]                     adx3_reg, ady3_reg;
    logic                               dxn3_reg, dyn3_reg;
    logic [edc2d_pkg::MSUM_W-1:0]       msum3_reg;
    logic [edc2d_pkg::MASS_W-1:0]       m1c_reg, m2c_reg;
    logic signed [NL-1:0][VW-1:0]       vel3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_SUM])
        begin
            s_reg     <= edc2d_pkg::DOT_W'(px_reg) + edc2d_pkg::DOT_W'(py_reg);
            d2_reg    <= edc2d_pkg::D2_W'(sqx_reg) + edc2d_pkg::D2_W'(sqy_reg);
            rsq_reg   <= CW'(rsum_reg) * CW'(rsum_reg);
            adx3_reg  <= adx2_reg;
            ady3_reg  <= ady2_reg;
            dxn3_reg  <= dxn2_reg;
            dyn3_reg  <= dyn2_reg;
            msum3_reg <= msum2_reg;
            m1c_reg   <= m1b_reg;
            m2c_reg   <= m2b_reg;
            vel3_reg  <= vel2_reg;
        end
    end

    // ---------------- Stage: overlap test and scaling ----------------
    logic [edc2d_pkg::DOT_W-1:0] as_next;
    logic [SCW-1:0]              sc1_reg, sc2_reg;
    logic [DFW-1:0]              adx4_reg, ady4_reg;
    logic [DW-1:0]               den4_reg;
    logic                        hit4_reg, negx4_reg, negy4_reg;
    logic signed [NL-1:0][VW-1:0] vel4_reg;

    assign as_next = s_reg[edc2d_pkg::DOT_W-1] ? edc2d_pkg::DOT_W'(-s_reg)
                                               : edc2d_pkg::DOT_W'(s_reg);

    always_ff @(posedge clk)
    begin
        if (adv[S_SCAL])
        begin
            hit4_reg  <= (d2_reg != '0) && (CMPW'(d2_reg) <= CMPW'(rsq_reg));
            sc1_reg   <= SCW'(as_next) * SCW'({m2c_reg, 1'b0});
            sc2_reg   <= SCW'(as_next) * SCW'({m1c_reg, 1'b0});
            den4_reg  <= DW'(d2_reg) * DW'(msum3_reg);
            negx4_reg <= s_reg[edc2d_pkg::DOT_W-1] ^ dxn3_reg;
            negy4_reg <= s_reg[edc2d_pkg::DOT_W-1] ^ dyn3_reg;
            adx4_reg  <= adx3_reg;
            ady4_reg  <= ady3_reg;
            vel4_reg  <= vel3_reg;
        end
    end

    // ---------------- Stage: split numerator products ----------------
    // Lanes: first x, first y, second x, second y.
    logic [NL-1:0][SCW-1:0] lane_sc;
    logic [NL-1:0][DFW-1:0] lane_ad;
    logic [NL-1:0][PW-1:0]  plo_reg, phi_reg;
    edc2d_pkg::div_ctx_t    ctx5_reg;

    assign lane_sc = {sc1_reg, sc1_reg, sc2_reg, sc2_reg};
    assign lane_ad = {adx4_reg, ady4_reg, adx4_reg, ady4_reg};

    always_ff @(posedge clk)
    begin
        if (adv[S_PART])
        begin
            for (int l = 0; l < NL; l++)
            begin
                plo_reg[l] <= PW'(lane_sc[l][HW-1:0]) * PW'(lane_ad[l]);
                phi_reg[l] <= PW'(lane_sc[l][SCW-1:HW]) * PW'(lane_ad[l]);
            end
            ctx5_reg.vel   <= vel4_reg;
            ctx5_reg.hit   <= hit4_reg;
            ctx5_reg.neg_x <= negx4_reg;
            ctx5_reg.neg_y <= negy4_reg;
            ctx5_reg.den   <= den4_reg;
        end
    end

    // ---------------- Divider: one quotient bit per stage ----------------
    edc2d_pkg::div_lane_t div_reg [QW+1][NL];
    edc2d_pkg::div_lane_t div_next[QW+1][NL];
    edc2d_pkg::div_ctx_t  ctx_reg [QW+1];

    always_comb
    begin
        logic [NW-1:0] num;
        logic [DW:0]   trial;
        logic          ge;
        for (int l = 0; l < NL; l++)
        begin
            num = (NW'(phi_reg[l]) << HW) + NW'(plo_reg[l]);
            div_next[0][l].rem = DW'(num[NW-1:QW]);
            div_next[0][l].quo = '0;
            div_next[0][l].nlo = num[QW-1:0];
        end
        for (int j = 1; j <= QW; j++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                trial = {div_reg[j-1][l].rem, div_reg[j-1][l].nlo[QW-1]};
                ge    = trial >= {1'b0, ctx_reg[j-1].den};
                div_next[j][l].rem = ge ? DW'(trial - {1'b0, ctx_reg[j-1].den})
                                        : DW'(trial);
                div_next[j][l].quo = {div_reg[j-1][l].quo[QW-2:0], ge};
                div_next[j][l].nlo = {div_reg[j-1][l].nlo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= QW; j++)
        begin
            if (adv[S_NUM+j])
            begin
                div_reg[j] <= div_next[j];
                ctx_reg[j] <= (j == 0) ? ctx5_reg : ctx_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // ---------------- Stage: rounding, ties away from zero ----------------
    logic [NL-1:0][QW:0]  qr_reg;
    edc2d_pkg::div_ctx_t  ctxr_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_RND])
        begin
            for (int l = 0; l < NL; l++)
            begin
                qr_reg[l] <= (QW+1)'(div_reg[QW][l].quo)
                           + (QW+1)'({div_reg[QW][l].rem, 1'b0}
                                     >= {1'b0, ctx_reg[QW].den});
            end
            ctxr_reg <= ctx_reg[QW];
        end
    end

    // ---------------- Stage: apply, saturate ----------------
    logic signed [NL-1:0][VW-1:0] res_next;

    always_comb
    begin
        logic signed [SUMW-1:0] corr;
        logic signed [SUMW-1:0] sum;
        logic                   neg;
        for (int l = 0; l < NL; l++)
        begin
            // The first disc gains the correction, the second loses it.
            neg  = ((l == 3 || l == 1) ? ctxr_reg.neg_x : ctxr_reg.neg_y) ^ (l < 2);
            corr = neg ? -SUMW'(qr_reg[l]) : SUMW'(qr_reg[l]);
            sum  = SUMW'($signed(ctxr_reg.vel[l])) + corr;
            if (!ctxr_reg.hit)
                res_next[l] = ctxr_reg.vel[l];
            else if (sum > SUMW'(edc2d_pkg::VEL_MAX))
                res_next[l] = edc2d_pkg::VEL_MAX;
            else if (sum < SUMW'(edc2d_pkg::VEL_MIN))
                res_next[l] = edc2d_pkg::VEL_MIN;
            else
                res_next[l] = VW'(sum);
        end
    end

    edc2d_pkg::disc_result_t out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            out_reg.new_first_vel_x  <= res_next[3];
            out_reg.new_first_vel_y  <= res_next[2];
            out_reg.new_second_vel_x <= res_next[1];
            out_reg.new_second_vel_y <= res_next[0];
            out_reg.hit              <= ctxr_reg.hit;
        end
    end

    assign out_data = out_reg;

    // ---------------- Assertions ----------------
    // In a resolved collision the final remainder of lane 0 stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_NUM+QW] && ctx_reg[QW].hit |-> div_reg[QW][0].rem < ctx_reg[QW].den)
        else $error("divider remainder not below divisor");

    // The correction is bounded by twice the relative speed, so the top bit stays clear.
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_RND] && ctxr_reg.hit |-> qr_reg[0][QW] == 1'b0 && qr_reg[3][QW] == 1'b0)
        else $error("rounded correction out of range");

    // A stalled result is never overwritten by the stage behind it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_OUT] && !out_ready |=> v_reg[S_OUT] && $stable(out_reg))
        else $error("pending result lost");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Elastic disc collision unit testbench
// Drives disc pairs through the valid/ready input, predicts all but typed-in
// results with its own fixed-point collision calculator and checks them in
// order, under several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 2000;
    localparam int N_PHASES   = 4;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 80;
    localparam int VW         = edc2d_pkg::VEL_W;
    localparam int MW         = edc2d_pkg::MASS_W;

    typedef struct {
        edc2d_pkg::disc_pair_t   pair;
        bit                      fixed;    // result typed in rather than predicted
        edc2d_pkg::disc_result_t want;
    } vector_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    edc2d_pkg::disc_pair_t   in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    edc2d_pkg::disc_result_t out_data;

    edc2d_pkg::disc_result_t pending_q[$];
    int           n_mismatch = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    bit           hold_req = 1'b0;
    vector_row_t  vectors[$];

    elastic_disc_collision_2d_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // One correction term, scale * mag / den, rounded half away from zero and capped at 2^40.
    function automatic logic signed [63:0] impulse_term(logic [63:0] scale, logic [63:0] mag,
                                                        logic [63:0] den, logic neg);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        num = {64'd0, scale} * {64'd0, mag};
        quo = num / {64'd0, den};
        rem = num % {64'd0, den};
        if (quo >= (128'd1 << 40))
            quo = 128'd1 << 40;
        else if ((rem << 1) >= {64'd0, den})
            quo = quo + 1;
        return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    function automatic logic signed [VW-1:0] clamp_vel(logic signed [63:0] v);
        if (v > 64'sd8388607)
            return edc2d_pkg::VEL_MAX;
        if (v < -64'sd8388608)
            return edc2d_pkg::VEL_MIN;
        return v[VW-1:0];
    endfunction

    function automatic edc2d_pkg::disc_result_t resolve_pair(edc2d_pkg::disc_pair_t p);
        logic signed [63:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
        logic signed [63:0] dx, dy, dot;
        logic signed [63:0] n1x, n1y, n2x, n2y;
        logic [63:0]        adx, ady, d2, rsum, msum, adot, den, sc1, sc2;
        edc2d_pkg::disc_result_t r;
        p1x = p.first_pos_x;   p1y = p.first_pos_y;
        p2x = p.second_pos_x;  p2y = p.second_pos_y;
        v1x = p.first_vel_x;   v1y = p.first_vel_y;
        v2x = p.second_vel_x;  v2y = p.second_vel_y;
        dx   = p2x - p1x;
        dy   = p2y - p1y;
        adx  = dx < 0 ? -dx : dx;
        ady  = dy < 0 ? -dy : dy;
        d2   = adx * adx + ady * ady;
        msum = 64'(p.first_mass) + 64'(p.second_mass);
        rsum = (3 * msum) << (edc2d_pkg::FRAC_BITS_DEFAULT - 2);
        n1x = v1x; n1y = v1y; n2x = v2x; n2y = v2y;
        r.hit = 1'b0;
        if (d2 != 0 && d2 <= rsum * rsum)
        begin
            dot  = (v2x - v1x) * dx + (v2y - v1y) * dy;
            adot = dot < 0 ? -dot : dot;
            den  = msum * d2;
            sc1  = 2 * 64'(p.second_mass) * adot;
            sc2  = 2 * 64'(p.first_mass) * adot;
            r.hit = 1'b1;
            n1x = v1x + impulse_term(sc1, adx, den, (dot < 0) != (dx < 0));
            n1y = v1y + impulse_term(sc1, ady, den, (dot < 0) != (dy < 0));
            n2x = v2x - impulse_term(sc2, adx, den, (dot < 0) != (dx < 0));
            n2y = v2y - impulse_term(sc2, ady, den, (dot < 0) != (dy < 0));
        end
        r.new_first_vel_x  = clamp_vel(n1x);
        r.new_first_vel_y  = clamp_vel(n1y);
        r.new_second_vel_x = clamp_vel(n2x);
        r.new_second_vel_y = clamp_vel(n2y);
        return r;
    endfunction

    function automatic edc2d_pkg::disc_pair_t make_pair(int p1x, int p1y, int v1x, int v1y,
                                                        int m1, int p2x, int p2y, int v2x,
                                                        int v2y, int m2);
        edc2d_pkg::disc_pair_t p;
        p.first_pos_x  = p1x[VW-1:0];  p.first_pos_y  = p1y[VW-1:0];
        p.first_vel_x  = v1x[VW-1:0];  p.first_vel_y  = v1y[VW-1:0];
        p.first_mass   = m1[MW-1:0];
        p.second_pos_x = p2x[VW-1:0];  p.second_pos_y = p2y[VW-1:0];
        p.second_vel_x = v2x[VW-1:0];  p.second_vel_y = v2y[VW-1:0];
        p.second_mass  = m2[MW-1:0];
        return p;
    endfunction

    function automatic void add_row(edc2d_pkg::disc_pair_t p, bit fixed);
        vector_row_t row;
        row.pair  = p;
        row.fixed = fixed;
        // Rows typed in leave the velocities untouched and report no hit.
        row.want  = {p.first_vel_x, p.first_vel_y, p.second_vel_x, p.second_vel_y, 1'b0};
        vectors.push_back(row);
    endfunction

    function automatic int rand_vel();
        if ($urandom_range(99) < 20)
            return $signed($urandom() << 8) >>> 8;
        return $signed($urandom_range(131071)) - 65536;
    endfunction

    function automatic edc2d_pkg::disc_pair_t random_pair();
        int m1, m2, reach, dx, dy, px, py;
        if ($urandom_range(99) < 20)
            return make_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        px = $signed($urandom() << 8) >>> 8;
        py = $signed($urandom() << 8) >>> 8;
        m1 = $urandom_range(99) < 70 ? $urandom_range(255, 1) : $urandom_range(255);
        m2 = $urandom_range(99) < 70 ? $urandom_range(255, 1) : $urandom_range(255);
        reach = 3 * (m1 + m2) * 64 + 1;
        if ($urandom_range(3) == 0)
            reach = reach / 16 + 1;
        dx = $signed($urandom_range(2 * reach)) - reach;
        dy = $signed($urandom_range(2 * reach)) - reach;
        return make_pair(px, py, rand_vel(), rand_vel(), m1,
                         px + dx, py + dy, rand_vel(), rand_vel(), m2);
    endfunction

    // Offers one pair and returns at the edge where the transfer takes place.
    task automatic offer_pair(edc2d_pkg::disc_pair_t p, edc2d_pkg::disc_result_t want);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.push_back(want);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: checks every transfer out and chooses the next ready level.
    initial
    begin
        edc2d_pkg::disc_result_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result transfer: %p", out_data);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (out_data !== want)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("wrong result: expected %p, got %p", want, out_data);
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5ms;
        $display("elastic_disc_collision_2d_unit: mismatch");
        $finish;
    end

    initial
    begin
        edc2d_pkg::disc_pair_t p;
        add_row('0, 1'b1);                                      // everything at zero
        add_row(make_pair(100, 100, 8388607, -8388608, 255,     // coincident centres
                          100, 100, -8388608, 8388607, 255), 1'b1);
        add_row(make_pair(-8388608, -8388608, 8388607, 8388607, 255,  // far apart
                          8388607, 8388607, -8388608, -8388608, 255), 1'b1);
        add_row(make_pair(0, 0, 256, 0, 4, 512, 0, -256, 0, 4), 1'b0);       // head-on
        add_row(make_pair(0, 0, 256, 0, 1, 384, 0, -256, 0, 1), 1'b0);       // just touching
        add_row(make_pair(0, 0, 256, 0, 1, 385, 0, -256, 0, 1), 1'b1);       // just apart
        add_row(make_pair(0, 0, 256, 128, 0, 1, 0, -256, 9, 0), 1'b1);      // both massless
        add_row(make_pair(0, 0, 256, 128, 0, 300, 40, -256, 9, 5), 1'b0);    // one massless
        add_row(make_pair(0, 0, 8388607, 0, 1, 1, 0, -8388608, 0, 255), 1'b0);  // saturation
        add_row(make_pair(0, 0, -8388608, 77, 255, -1, 0, 8388607, -5, 1), 1'b0);
        add_row(make_pair(500, 200, 300, -900, 10, 200, 0, -40, 600, 20), 1'b0);
        add_row(make_pair(0, 0, 0, 1000, 255, 0, 90000, 0, -1000, 255), 1'b0);
        add_row(make_pair(0, 0, -500, 0, 7, 900, 0, 500, 0, 3), 1'b0);      // receding
        add_row(make_pair(8388607, 8388607, 1, 2, 200, 8388000, 8388500, 3, 4, 100), 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[k])
            offer_pair(vectors[k].pair,
                       vectors[k].fixed ? vectors[k].want : resolve_pair(vectors[k].pair));
        wait_drained();

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            for (int k = 0; k < N_RANDOM / N_PHASES; k++)
            begin
                idle_pct  = (phase == 1) ? 69 : (phase == 3) ? 11 : 0;
                stall_pct = (phase == 2) ? 69 : (phase == 3) ? 11 : 0;
                if (phase == 0 && k == 20)
                    hold_req = 1'b1;
                // A short burst with no idling or stalling now and then, even in the idling phases.
                if (k % 100 >= 50 && k % 100 < 60)
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                p = random_pair();
                offer_pair(p, resolve_pair(p));
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_mismatch == 0 && pending_q.size() == 0)
            $display("elastic_disc_collision_2d_unit: match");
        else
            $display("elastic_disc_collision_2d_unit: mismatch");
        $finish;
    end

endmodule
